>>> rtl/cpio_pkg.sv
// Package for the cpio newc stream parser: phases, result kinds, error codes and helpers.
package cpio_pkg;

  localparam int unsigned NameLimitDef = 4096;
  localparam int unsigned HeaderBytes  = 110;
  localparam int unsigned MagicLen     = 6;
  localparam int unsigned TrailerLen   = 10;

  localparam logic [4:0] TrailerHit  = 5'd11;
  localparam logic [4:0] TrailerMiss = 5'd31;

  localparam logic [3:0] FmtReg = 4'o10;
  localparam logic [3:0] FmtLnk = 4'o12;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_HEADER    = 7'b0000010,
    PH_NAME      = 7'b0000100,
    PH_BODY      = 7'b0001000,
    PH_PAD_SKIP  = 7'b0010000,
    PH_SKIP_NAME = 7'b0100000,
    PH_SKIP_BODY = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_FIELD   = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_BODY    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_TRAILER = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  localparam logic [31:0] ErrPadding = 32'd1;
  localparam logic [31:0] ErrOldCpio = 32'd2;
  localparam logic [31:0] ErrNoMagic = 32'd3;
  localparam logic [31:0] ErrNameEnd = 32'd4;
  localparam logic [31:0] ErrSum     = 32'd5;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] index;
    logic [31:0] value;
    logic        last;
  } result_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] magic_char(logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd1, 3'd3: r = 8'h37;
      default:    r = 8'h30;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trailer_char(logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0:    r = 8'h54;
      4'd1:    r = 8'h52;
      4'd2:    r = 8'h41;
      4'd3:    r = 8'h49;
      4'd4:    r = 8'h4c;
      4'd5:    r = 8'h45;
      4'd6:    r = 8'h52;
      default: r = 8'h21;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cpio_newc_stream_parser.sv
// cpio newc stream parser: one archive byte per transfer in, a stream of parse results out.
// One byte is accepted per cycle while the result queue has room for three results; each byte is
// parsed in the cycle it is accepted and its zero to three results are written into a four-entry
// queue, which the output drains at one result per cycle while not stalled. So the sustained
// rate is one byte per cycle for bytes giving at most one result, and is set by the output side
// otherwise. After an error the parser stays stopped and gives no more results until reset.
module cpio_newc_stream_parser import cpio_pkg::*; #(
  parameter int unsigned NAME_LIMIT = NameLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [11:0] index_o,
  output logic [31:0] value_o,
  output logic        last_o
);

  localparam int unsigned NPW = $clog2(NAME_LIMIT + 4);

  phase_e          phase_q, phase_d;
  logic [6:0]      hpos_q, hpos_d;
  logic [31:0]     acc_q, acc_d;
  logic            stop_q, stop_d;
  logic [31:0]     mode_q, mode_d, nsize_q, nsize_d, bsize_q, bsize_d, check_q, check_d;
  logic [32:0]     left_q, left_d;
  logic [1:0]      align_q, align_d;
  logic [31:0]     sum_q, sum_d;
  logic            sumen_q, sumen_d;
  logic [4:0]      trl_q, trl_d;
  logic            err_q, err_d;
  logic [NPW-1:0]  npos_q, npos_d;

  result_t         res [3];
  logic [1:0]      n_res;

  result_t         fifo_q [4];
  logic [1:0]      rd_q, wr_q;
  logic [2:0]      cnt_q;

  logic            push, pop;

  assign in_ready_o  = (cnt_q <= 3'd1);
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    logic [7:0]  b;
    logic        halt;
    logic [4:0]  h;
    logic [6:0]  rel;
    logic [3:0]  fnum;
    logic [1:0]  pad;
    logic [3:0]  fmt;
    logic        keep;
    logic        lnk;
    logic        reg_f;
    logic [NPW-1:0] p;
    logic        enter;
    phase_e      eph;

    b = data_i;
    halt = 1'b0;
    enter = 1'b0;
    eph = PH_BODY;
    pad = 2'd0;
    fmt = 4'd0;
    keep = 1'b0;
    lnk = 1'b0;
    reg_f = 1'b0;
    h = hex_val(b);
    rel = hpos_q - 7'(MagicLen);
    fnum = rel[6:3];
    p = npos_q;

    phase_d = phase_q; hpos_d = hpos_q; acc_d = acc_q; stop_d = stop_q;
    mode_d = mode_q; nsize_d = nsize_q; bsize_d = bsize_q; check_d = check_q;
    left_d = left_q; align_d = align_q; sum_d = sum_q; sumen_d = sumen_q;
    trl_d = trl_q; err_d = err_q; npos_d = npos_q;
    n_res = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '{kind: KIND_FIELD, index: 12'd0, value: 32'd0, last: 1'b0};
    end

    if (push && !err_q) begin
      if (phase_q == PH_IDLE) begin
        if (b == 8'd0) begin
          align_d = align_q + 2'd1;
          halt = 1'b1;
        end else if (align_q != 2'd0) begin
          res[0] = '{kind: KIND_ERROR, index: 12'd0, value: ErrPadding, last: 1'b0};
          n_res = 2'd1; err_d = 1'b1; halt = 1'b1;
        end else begin
          phase_d = PH_HEADER;
          stop_d = 1'b0;
        end
      end

      if (!halt && (phase_q == PH_IDLE || phase_q == PH_HEADER)) begin
        if (phase_q == PH_IDLE) rel = 7'd0 - 7'(MagicLen);
        if (phase_q == PH_IDLE || hpos_q < 7'(MagicLen)) begin
          if (phase_q == PH_IDLE || hpos_q < 7'(MagicLen - 1)) begin
            if (b != magic_char(phase_q == PH_IDLE ? 3'd0 : hpos_q[2:0])) stop_d = 1'b1;
          end else if (stop_q) begin
            res[0] = '{kind: KIND_ERROR, index: 12'd0, value: ErrNoMagic, last: 1'b0};
            n_res = 2'd1; err_d = 1'b1;
          end else if (b == 8'h31) begin
            sumen_d = 1'b0;
          end else if (b == 8'h32) begin
            sumen_d = 1'b1;
          end else if (b == 8'h37) begin
            res[0] = '{kind: KIND_ERROR, index: 12'd0, value: ErrOldCpio, last: 1'b0};
            n_res = 2'd1; err_d = 1'b1;
          end else begin
            res[0] = '{kind: KIND_ERROR, index: 12'd0, value: ErrNoMagic, last: 1'b0};
            n_res = 2'd1; err_d = 1'b1;
          end
          hpos_d = (phase_q == PH_IDLE) ? 7'd1 : hpos_q + 7'd1;
        end else begin
          acc_d = acc_q;
          stop_d = stop_q;
          if (rel[2:0] == 3'd0) begin
            acc_d = 32'd0;
            stop_d = 1'b0;
          end
          if (!stop_d && !h[4]) acc_d = {acc_d[27:0], h[3:0]};
          else stop_d = 1'b1;
          if (rel[2:0] == 3'd7) begin
            res[0] = '{kind: KIND_FIELD, index: 12'(fnum), value: acc_d, last: 1'b0};
            n_res = 2'd1;
            case (fnum)
              4'd1:    mode_d = acc_d;
              4'd6:    bsize_d = acc_d;
              4'd11:   nsize_d = acc_d;
              4'd12:   check_d = acc_d;
              default: ;
            endcase
          end
          if (hpos_q >= 7'(HeaderBytes - 1)) begin
            fmt = mode_d[15:12];
            sum_d = 32'd0;
            trl_d = 5'd0;
            npos_d = '0;
            left_d = ({1'b0, nsize_d} + 33'd1) & ~33'd3;
            left_d = left_d + 33'd2;
            if (nsize_d == 32'd0 || nsize_d > 32'(NAME_LIMIT)) keep = 1'b0;
            else if (fmt == FmtLnk) keep = (bsize_d <= 32'(NAME_LIMIT));
            else keep = (fmt == FmtReg) || (bsize_d == 32'd0);
            phase_d = keep ? PH_NAME : PH_SKIP_NAME;
          end else begin
            hpos_d = hpos_q + 7'd1;
          end
        end
      end

      if (phase_q == PH_NAME) begin
        lnk = (mode_q[15:12] == FmtLnk);
        reg_f = (mode_q[15:12] == FmtReg);
        npos_d = npos_q + NPW'(1);
        if (32'(p) < nsize_q) begin
          res[0] = '{kind: KIND_NAME, index: 12'(p), value: {24'd0, b}, last: 1'b0};
          n_res = 2'd1;
          if (!lnk) begin
            if (32'(p) < 32'(TrailerLen) && trl_q == 5'(p) && b == trailer_char(4'(p)))
              trl_d = 5'(p) + 5'd1;
            else if (trl_q == 5'(TrailerLen) && 32'(p) == 32'(TrailerLen) && b == 8'd0)
              trl_d = TrailerHit;
            else if (trl_q != TrailerHit)
              trl_d = TrailerMiss;
          end
          if (32'(p) == nsize_q - 32'd1) begin
            if (b != 8'd0) begin
              res[1] = '{kind: KIND_ERROR, index: 12'd0, value: ErrNameEnd, last: 1'b0};
              n_res = 2'd2; err_d = 1'b1; halt = 1'b1;
            end else if (!lnk && trl_d == TrailerHit) begin
              res[1] = '{kind: KIND_TRAILER, index: 12'd0, value: 32'd0, last: 1'b0};
              n_res = 2'd2;
            end
          end
        end
        if (!halt) begin
          if (left_q != 33'd0) left_d = left_q - 33'd1;
          if (left_d == 33'd0) begin
            enter = 1'b1;
            if (lnk) eph = PH_BODY;
            else if (trl_d == TrailerHit) eph = PH_PAD_SKIP;
            else if (reg_f) eph = PH_BODY;
            else eph = PH_PAD_SKIP;
          end
        end
      end

      if (phase_q == PH_BODY) begin
        pad = 2'd0 - bsize_q[1:0];
        reg_f = (mode_q[15:12] == FmtReg);
        if (left_q > {31'd0, pad}) begin
          res[0] = '{kind: KIND_BODY, index: 12'd0, value: {24'd0, b}, last: 1'b0};
          n_res = 2'd1;
          if (reg_f) sum_d = sum_q + {24'd0, b};
          if (left_q == {31'd0, pad} + 33'd1 && sumen_q && reg_f && sum_d != check_q) begin
            res[1] = '{kind: KIND_ERROR, index: 12'd0, value: ErrSum, last: 1'b0};
            n_res = 2'd2; err_d = 1'b1; halt = 1'b1;
          end
        end
        if (!halt) begin
          if (left_q != 33'd0) left_d = left_q - 33'd1;
          if (left_d == 33'd0) begin
            res[n_res] = '{kind: KIND_DONE, index: 12'd0, value: 32'd0, last: 1'b0};
            n_res = n_res + 2'd1;
            phase_d = PH_IDLE; align_d = 2'd0;
          end
        end
      end

      if (phase_q == PH_PAD_SKIP || phase_q == PH_SKIP_NAME || phase_q == PH_SKIP_BODY) begin
        if (left_q != 33'd0) left_d = left_q - 33'd1;
        if (left_d == 33'd0) begin
          if (phase_q == PH_SKIP_NAME) begin
            enter = 1'b1;
            eph = PH_SKIP_BODY;
          end else begin
            res[0] = '{kind: KIND_DONE, index: 12'd0,
                       value: {31'd0, phase_q == PH_SKIP_BODY}, last: 1'b0};
            n_res = 2'd1;
            phase_d = PH_IDLE; align_d = 2'd0;
          end
        end
      end

      if (enter) begin
        pad = 2'd0 - bsize_q[1:0];
        phase_d = eph;
        left_d = {1'b0, bsize_q} + {31'd0, pad};
        if (left_d == 33'd0) begin
          if (eph == PH_BODY && sumen_q && mode_q[15:12] == FmtReg && sum_d != check_q) begin
            res[n_res] = '{kind: KIND_ERROR, index: 12'd0, value: ErrSum, last: 1'b0};
            err_d = 1'b1;
          end else begin
            res[n_res] = '{kind: KIND_DONE, index: 12'd0,
                           value: {31'd0, eph == PH_SKIP_BODY}, last: 1'b0};
            phase_d = PH_IDLE; align_d = 2'd0;
          end
          n_res = n_res + 2'd1;
        end
      end

      if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; hpos_q <= '0; acc_q <= '0; stop_q <= 1'b0;
      mode_q <= '0; nsize_q <= '0; bsize_q <= '0; check_q <= '0;
      left_q <= '0; align_q <= '0; sum_q <= '0; sumen_q <= 1'b0;
      trl_q <= '0; err_q <= 1'b0; npos_q <= '0;
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      phase_q <= phase_d; hpos_q <= hpos_d; acc_q <= acc_d; stop_q <= stop_d;
      mode_q <= mode_d; nsize_q <= nsize_d; bsize_q <= bsize_d; check_q <= check_d;
      left_q <= left_d; align_q <= align_d; sum_q <= sum_d; sumen_q <= sumen_d;
      trl_q <= trl_d; err_q <= err_d; npos_q <= npos_d;
      wr_q <= wr_q + n_res;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, n_res} - {2'd0, pop};
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_res) fifo_q[wr_q + 2'(k)] <= res[k];
    end
  end

  assign kind_o  = fifo_q[rd_q].kind;
  assign index_o = fifo_q[rd_q].index;
  assign value_o = fifo_q[rd_q].value;
  assign last_o  = fifo_q[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |=> err_q)
    else $error("error latch cleared");
  a_no_res_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> n_res == 2'd0)
    else $error("result after latched error");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_res != 2'd0 |-> cnt_q <= 3'd1)
    else $error("result written without queue room");

endmodule
